// ----- hw/rtl/sjc_pkg.sv -----
// Shared types and constants for the slip junction classifier.
// No dependencies.
package sjc_pkg;

	localparam int COMPONENT_WIDTH_DEF = 16;
	localparam int LIMIT_W = 16;
	localparam int TSQ_W = 2 * LIMIT_W;
	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] REG_PERP = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PARALLEL = 1'd1;

	localparam logic [LIMIT_W-1:0] PERP_RESET = 16'd1311;
	localparam logic [LIMIT_W-1:0] PARALLEL_RESET = 16'd64225;

	typedef enum logic [2:0] {
		KIND_NONE     = 3'd0,
		KIND_HIRTH    = 3'd1,
		KIND_COPLANAR = 3'd2,
		KIND_GLISSILE = 3'd3,
		KIND_SESSILE  = 3'd4
	} kind_t;

	// cosine test outcome for one vector pair
	typedef struct packed {
		logic lt_perp;
		logic gt_par;
	} cos_flags_t;

endpackage

// ----- hw/rtl/sjc_cos_unit.sv -----
// Pipelined exact cosine test of one vector pair against both squared limits.
// Depends on sjc_pkg. Five register stages, s2 through s6.
module sjc_cos_unit #(
	parameter int VW = 16
) (
	input  logic                         clk,
	input  logic signed [VW-1:0]         u [3],
	input  logic signed [VW-1:0]         v [3],
	input  logic [sjc_pkg::TSQ_W-1:0]    perp_sq,
	input  logic [sjc_pkg::TSQ_W-1:0]    par_sq,
	output sjc_pkg::cos_flags_t          flags
);
	import sjc_pkg::*;

	localparam int PW = 2 * VW;     // component product
	localparam int DW = 2 * VW + 1; // signed dot sum
	localparam int MW = 2 * VW;     // |dot| and squared norm
	localparam int QW = 4 * VW;     // dot^2 and norm product
	localparam int HW = 2 * VW;     // half of the norm product
	localparam int PPW = TSQ_W + HW;
	localparam int RW = QW + TSQ_W;

	logic signed [PW-1:0] uv_s2 [3];
	logic [PW-1:0]        uu_s2 [3];
	logic [PW-1:0]        vv_s2 [3];
	logic signed [DW-1:0] dot_c;
	logic [MW-1:0]        mag_s3;
	logic [MW-1:0]        nu_s3;
	logic [MW-1:0]        nv_s3;
	logic [QW-1:0]        dsq_s4;
	logic [QW-1:0]        nn_s4;
	logic [QW-1:0]        dsq_s5;
	logic [PPW-1:0]       perp_lo_s5;
	logic [PPW-1:0]       perp_hi_s5;
	logic [PPW-1:0]       par_lo_s5;
	logic [PPW-1:0]       par_hi_s5;
	logic [RW-1:0]        lhs_c;
	logic [RW-1:0]        rhs_perp_c;
	logic [RW-1:0]        rhs_par_c;
	cos_flags_t           flags_s6;

	// s2: component products
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			uv_s2[i] <= PW'(u[i]) * PW'(v[i]);
			uu_s2[i] <= $unsigned(PW'(u[i]) * PW'(u[i]));
			vv_s2[i] <= $unsigned(PW'(v[i]) * PW'(v[i]));
		end
	end

	// s3: dot magnitude and squared norms
	always_comb begin
		dot_c = DW'(uv_s2[0]) + DW'(uv_s2[1]) + DW'(uv_s2[2]);
	end

	always_ff @(posedge clk) begin
		mag_s3 <= MW'(dot_c[DW-1] ? -dot_c : dot_c);
		nu_s3  <= uu_s2[0] + uu_s2[1] + uu_s2[2];
		nv_s3  <= vv_s2[0] + vv_s2[1] + vv_s2[2];
	end

	// s4: dot^2 and |u|^2 |v|^2
	always_ff @(posedge clk) begin
		dsq_s4 <= QW'(mag_s3) * QW'(mag_s3);
		nn_s4  <= QW'(nu_s3) * QW'(nv_s3);
	end

	// s5: limit^2 times norm product, as two half-width partial products
	always_ff @(posedge clk) begin
		dsq_s5     <= dsq_s4;
		perp_lo_s5 <= PPW'(perp_sq) * PPW'(nn_s4[HW-1:0]);
		perp_hi_s5 <= PPW'(perp_sq) * PPW'(nn_s4[QW-1:HW]);
		par_lo_s5  <= PPW'(par_sq) * PPW'(nn_s4[HW-1:0]);
		par_hi_s5  <= PPW'(par_sq) * PPW'(nn_s4[QW-1:HW]);
	end

	// s6: strict compares, lhs is dot^2 scaled by 2^32
	always_comb begin
		lhs_c      = {dsq_s5, {TSQ_W{1'b0}}};
		rhs_perp_c = RW'(perp_lo_s5) + (RW'(perp_hi_s5) << HW);
		rhs_par_c  = RW'(par_lo_s5) + (RW'(par_hi_s5) << HW);
	end

	always_ff @(posedge clk) begin
		flags_s6.lt_perp <= lhs_c < rhs_perp_c;
		flags_s6.gt_par  <= lhs_c > rhs_par_c;
	end

	assign flags = flags_s6;

endmodule

// ----- hw/rtl/slip_junction_classifier.sv -----
// Top level of the slip junction classifier: input capture, four cosine units,
// final classification and the limit registers. Depends on sjc_pkg, sjc_cos_unit.

// Classifies the junction of two slip systems. A transaction is taken on any
// cycle with start high (busy is always low), so one pair enters per clock.
// The result appears on junction_kind with done high for one cycle; the
// results leave in order and the receiver cannot stall them. The seven-stage
// pipeline is input capture, component products, sums, squaring, split limit
// products, the wide compare, and classification. The user must write limits
// through cfg_we/cfg_addr/cfg_wdata only while no transaction is in flight;
// the block itself does not enforce this.
module slip_junction_classifier #(
	parameter int COMPONENT_WIDTH = sjc_pkg::COMPONENT_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic signed [COMPONENT_WIDTH-1:0] burg_a_x,
	input  logic signed [COMPONENT_WIDTH-1:0] burg_a_y,
	input  logic signed [COMPONENT_WIDTH-1:0] burg_a_z,
	input  logic signed [COMPONENT_WIDTH-1:0] norm_a_x,
	input  logic signed [COMPONENT_WIDTH-1:0] norm_a_y,
	input  logic signed [COMPONENT_WIDTH-1:0] norm_a_z,
	input  logic signed [COMPONENT_WIDTH-1:0] burg_b_x,
	input  logic signed [COMPONENT_WIDTH-1:0] burg_b_y,
	input  logic signed [COMPONENT_WIDTH-1:0] burg_b_z,
	input  logic signed [COMPONENT_WIDTH-1:0] norm_b_x,
	input  logic signed [COMPONENT_WIDTH-1:0] norm_b_y,
	input  logic signed [COMPONENT_WIDTH-1:0] norm_b_z,
	input  logic                              cfg_we,
	input  logic [sjc_pkg::CFG_IDX_W-1:0]     cfg_addr,
	input  logic [sjc_pkg::LIMIT_W-1:0]       cfg_wdata,
	output logic                              done,
	output logic [2:0]                        junction_kind
);
	import sjc_pkg::*;

	localparam int W = COMPONENT_WIDTH;
	localparam int SW = COMPONENT_WIDTH + 1;
	localparam int LATENCY = 7;
	localparam logic [TSQ_W-1:0] PERP_SQ_RESET = TSQ_W'(PERP_RESET) * TSQ_W'(PERP_RESET);
	localparam logic [TSQ_W-1:0] PAR_SQ_RESET =
		TSQ_W'(PARALLEL_RESET) * TSQ_W'(PARALLEL_RESET);

	logic [LIMIT_W-1:0] perp_q;
	logic [LIMIT_W-1:0] par_q;
	logic [TSQ_W-1:0]   perp_sq_q;
	logic [TSQ_W-1:0]   par_sq_q;

	logic signed [W-1:0]  ba_s1 [3];
	logic signed [W-1:0]  bb_s1 [3];
	logic signed [W-1:0]  na_s1 [3];
	logic signed [W-1:0]  nb_s1 [3];
	logic signed [SW-1:0] bs_s1 [3];
	logic signed [SW-1:0] nax_c [3];
	logic signed [SW-1:0] nbx_c [3];

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic done_q;
	kind_t kind_q;
	kind_t kind_c;

	cos_flags_t f_bb, f_nn, f_na, f_nb;

	assign busy = 1'b0;

	// limit registers and their squares
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			perp_q <= PERP_RESET;
			par_q  <= PARALLEL_RESET;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_PERP:     perp_q <= cfg_wdata;
				REG_PARALLEL: par_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			perp_sq_q <= PERP_SQ_RESET;
			par_sq_q  <= PAR_SQ_RESET;
		end else begin
			perp_sq_q <= TSQ_W'(perp_q) * TSQ_W'(perp_q);
			par_sq_q  <= TSQ_W'(par_q) * TSQ_W'(par_q);
		end
	end

	// s1: capture, Burgers sum
	always_ff @(posedge clk) begin
		ba_s1 <= '{burg_a_x, burg_a_y, burg_a_z};
		bb_s1 <= '{burg_b_x, burg_b_y, burg_b_z};
		na_s1 <= '{norm_a_x, norm_a_y, norm_a_z};
		nb_s1 <= '{norm_b_x, norm_b_y, norm_b_z};
		bs_s1[0] <= SW'(burg_a_x) + SW'(burg_b_x);
		bs_s1[1] <= SW'(burg_a_y) + SW'(burg_b_y);
		bs_s1[2] <= SW'(burg_a_z) + SW'(burg_b_z);
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			nax_c[i] = SW'(na_s1[i]);
			nbx_c[i] = SW'(nb_s1[i]);
		end
	end

	sjc_cos_unit #(.VW(W)) u_cos_bb (
		.clk(clk), .u(ba_s1), .v(bb_s1),
		.perp_sq(perp_sq_q), .par_sq(par_sq_q), .flags(f_bb)
	);

	sjc_cos_unit #(.VW(W)) u_cos_nn (
		.clk(clk), .u(na_s1), .v(nb_s1),
		.perp_sq(perp_sq_q), .par_sq(par_sq_q), .flags(f_nn)
	);

	sjc_cos_unit #(.VW(SW)) u_cos_na (
		.clk(clk), .u(nax_c), .v(bs_s1),
		.perp_sq(perp_sq_q), .par_sq(par_sq_q), .flags(f_na)
	);

	sjc_cos_unit #(.VW(SW)) u_cos_nb (
		.clk(clk), .u(nbx_c), .v(bs_s1),
		.perp_sq(perp_sq_q), .par_sq(par_sq_q), .flags(f_nb)
	);

	// valid bits follow the data through the units
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			done_q <= vld_s6;
		end
	end

	// fixed test order
	always_comb begin
		if (f_bb.lt_perp)
			kind_c = KIND_HIRTH;
		else if (f_bb.gt_par)
			kind_c = KIND_NONE;
		else if (f_nn.gt_par)
			kind_c = KIND_COPLANAR;
		else if (f_na.lt_perp || f_nb.lt_perp)
			kind_c = KIND_GLISSILE;
		else
			kind_c = KIND_SESSILE;
	end

	always_ff @(posedge clk) begin
		kind_q <= kind_c;
	end

	assign done = done_q;
	assign junction_kind = kind_q;

	a_done_from_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LATENCY))
		else $error("result without a matching start");

	a_start_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s6 |=> done)
		else $error("transaction dropped at the output");

	a_perp_square: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_we && cfg_addr == REG_PERP) |=> ##1
		perp_sq_q == TSQ_W'($past(cfg_wdata, 2)) * TSQ_W'($past(cfg_wdata, 2)))
		else $error("perp limit square out of step with its register");

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for slip_junction_classifier: a directed table, then random
// slip-system pairs under several limit settings; rows without a typed kind are scored by
// a bit-exact predictor. Depends on sjc_pkg and the classifier RTL.
module testbench;
	import sjc_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int PIPE_DRAIN = 12;
	localparam int ITEMS_PER_PHASE = 240;
	localparam int NUM_PHASES = 6;

	typedef logic [0:2][15:0] comp3_t;
	typedef int vec3_t [3];
	typedef struct packed {
		comp3_t burg_a;
		comp3_t norm_a;
		comp3_t burg_b;
		comp3_t norm_b;
	} slip_pair_t;
	typedef struct {
		slip_pair_t pair;
		kind_t      kind;
		bit         known;
	} stim_row_t;

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	logic signed [15:0] burg_a_x, burg_a_y, burg_a_z;
	logic signed [15:0] norm_a_x, norm_a_y, norm_a_z;
	logic signed [15:0] burg_b_x, burg_b_y, burg_b_z;
	logic signed [15:0] norm_b_x, norm_b_y, norm_b_z;
	logic              cfg_we;
	logic [CFG_IDX_W-1:0] cfg_addr;
	logic [LIMIT_W-1:0]   cfg_wdata;
	logic              done;
	logic [2:0]        junction_kind;

	logic [15:0] lim_perp = PERP_RESET;
	logic [15:0] lim_par = PARALLEL_RESET;
	kind_t       expected_kinds[$];
	stim_row_t   stim_rows[$];
	int          mismatch_count = 0;
	int          sent_count = 0;
	int          cycle_count = 0;
	int          kind_seen [5] = '{0, 0, 0, 0, 0};

	slip_junction_classifier i_dut (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("[slip_junction_classifier] ERROR");
			$finish;
		end
	end

	// ---- predictor ----

	// sign of (u.v)^2 * 2^32 - t^2 * |u|^2 * |v|^2
	function automatic int cos_order(vec3_t u, vec3_t v, logic [15:0] t);
		longint dot, nu, nv;
		logic [127:0] lhs, rhs;
		dot = 0;
		nu = 0;
		nv = 0;
		for (int i = 0; i < 3; i++) begin
			dot += longint'(u[i]) * longint'(v[i]);
			nu += longint'(u[i]) * longint'(u[i]);
			nv += longint'(v[i]) * longint'(v[i]);
		end
		if (dot < 0)
			dot = -dot;
		lhs = (128'(dot) * 128'(dot)) << 32;
		rhs = 128'(t) * 128'(t) * 128'(nu) * 128'(nv);
		if (lhs < rhs)
			return -1;
		return (lhs > rhs) ? 1 : 0;
	endfunction

	function automatic kind_t classify_pair(slip_pair_t p, logic [15:0] perp, logic [15:0] par);
		vec3_t ba, na, bb, nb, bs;
		for (int i = 0; i < 3; i++) begin
			ba[i] = int'($signed(p.burg_a[i]));
			na[i] = int'($signed(p.norm_a[i]));
			bb[i] = int'($signed(p.burg_b[i]));
			nb[i] = int'($signed(p.norm_b[i]));
			bs[i] = ba[i] + bb[i];
		end
		if (cos_order(ba, bb, perp) < 0)
			return KIND_HIRTH;
		if (cos_order(ba, bb, par) > 0)
			return KIND_NONE;
		if (cos_order(na, nb, par) > 0)
			return KIND_COPLANAR;
		if (cos_order(na, bs, perp) < 0 || cos_order(nb, bs, perp) < 0)
			return KIND_GLISSILE;
		return KIND_SESSILE;
	endfunction

	// ---- stimulus helpers ----

	function automatic comp3_t pack3(vec3_t v);
		comp3_t r;
		int c;
		for (int i = 0; i < 3; i++) begin
			c = v[i];
			if (c > 32767)
				c = 32767;
			if (c < -32768)
				c = -32768;
			r[i] = 16'(c);
		end
		return r;
	endfunction

	function automatic comp3_t vec(int x, int y, int z);
		vec3_t v;
		v[0] = x;
		v[1] = y;
		v[2] = z;
		return pack3(v);
	endfunction

	function automatic int wobble(int jit);
		if (jit == 0)
			return 0;
		return int'($urandom_range(2 * jit)) - jit;
	endfunction

	function automatic int pick_scale();
		case ($urandom_range(4))
			0: return 8192;
			1: return 4096;
			2: return 16384;
			3: return 32767;
			default: return int'($urandom_range(1, 32767));
		endcase
	endfunction

	// crystal-like direction: components from {-s, 0, s}, optionally jittered
	function automatic void lattice_dir(output vec3_t v, input int jit);
		int s;
		s = pick_scale();
		for (int i = 0; i < 3; i++)
			v[i] = (int'($urandom_range(2)) - 1) * s + wobble(jit);
	endfunction

	function automatic void extreme_dir(output vec3_t v);
		for (int i = 0; i < 3; i++)
			v[i] = $urandom_range(1) ? 32767 : -32768;
	endfunction

	function automatic slip_pair_t random_pair();
		vec3_t ba, na, bb, nb, ex;
		slip_pair_t p;
		int mode, jit, sgn;
		mode = int'($urandom_range(99));
		if (mode < 8) begin
			p = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
			return p;
		end
		jit = ($urandom_range(2) == 0) ? int'($urandom_range(1, 300)) : 0;
		lattice_dir(ba, jit);
		lattice_dir(na, jit);
		lattice_dir(bb, jit);
		lattice_dir(nb, jit);
		sgn = $urandom_range(1) ? 1 : -1;
		case ($urandom_range(3))
			0: for (int i = 0; i < 3; i++) bb[i] = sgn * ba[i] + wobble(jit);
			1: for (int i = 0; i < 3; i++) nb[i] = sgn * na[i] + wobble(jit);
			default: ;
		endcase
		if (mode < 15) begin
			extreme_dir(ex);
			case ($urandom_range(3))
				0: ba = ex;
				1: na = ex;
				2: bb = ex;
				default: nb = ex;
			endcase
		end
		p.burg_a = pack3(ba);
		p.norm_a = pack3(na);
		p.burg_b = pack3(bb);
		p.norm_b = pack3(nb);
		return p;
	endfunction

	function automatic void add_row(comp3_t ba, comp3_t na, comp3_t bb, comp3_t nb,
			kind_t kind, bit known);
		stim_row_t r;
		r.pair = {ba, na, bb, nb};
		r.kind = kind;
		r.known = known;
		stim_rows.push_back(r);
	endfunction

	// ---- driving ----

	task automatic send_pair(slip_pair_t p, int idle_pct, bit known, kind_t typed);
		while (int'($urandom_range(99)) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		burg_a_x <= p.burg_a[0];
		burg_a_y <= p.burg_a[1];
		burg_a_z <= p.burg_a[2];
		norm_a_x <= p.norm_a[0];
		norm_a_y <= p.norm_a[1];
		norm_a_z <= p.norm_a[2];
		burg_b_x <= p.burg_b[0];
		burg_b_y <= p.burg_b[1];
		burg_b_z <= p.burg_b[2];
		norm_b_x <= p.norm_b[0];
		norm_b_y <= p.norm_b[1];
		norm_b_z <= p.norm_b[2];
		@(posedge clk);
		while (busy)
			@(posedge clk);
		expected_kinds.push_back(known ? typed : classify_pair(p, lim_perp, lim_par));
		sent_count++;
	endtask

	task automatic drain_pipe();
		start <= 1'b0;
		while (expected_kinds.size() != 0)
			@(posedge clk);
		repeat (PIPE_DRAIN) @(posedge clk);
	endtask

	task automatic program_limits(logic [15:0] perp, logic [15:0] par);
		cfg_we <= 1'b1;
		cfg_addr <= REG_PERP;
		cfg_wdata <= perp;
		@(posedge clk);
		cfg_addr <= REG_PARALLEL;
		cfg_wdata <= par;
		@(posedge clk);
		cfg_we <= 1'b0;
		lim_perp = perp;
		lim_par = par;
	endtask

	// ---- checking ----

	task automatic report_mismatch(string msg);
		$display("mismatch @%0t: %s", $realtime, msg);
		mismatch_count++;
	endtask

	always @(posedge clk) begin
		kind_t want;
		if (arst_n && done) begin
			if (junction_kind <= 3'd4)
				kind_seen[junction_kind]++;
			if (expected_kinds.size() == 0) begin
				report_mismatch($sformatf("unexpected result kind %0d", junction_kind));
			end else begin
				want = expected_kinds.pop_front();
				if (junction_kind !== want)
					report_mismatch($sformatf("junction_kind got %0d want %0d (%s)",
						junction_kind, want, want.name()));
			end
		end
	end

	// ---- main sequence ----

	initial begin
		logic [15:0] perp_set [NUM_PHASES];
		logic [15:0] par_set [NUM_PHASES];
		int idle_set [NUM_PHASES];
		arst_n <= 1'b0;
		start <= 1'b0;
		{burg_a_x, burg_a_y, burg_a_z, norm_a_x, norm_a_y, norm_a_z} <= '0;
		{burg_b_x, burg_b_y, burg_b_z, norm_b_x, norm_b_y, norm_b_z} <= '0;
		cfg_we <= 1'b0;
		cfg_addr <= REG_PERP;
		cfg_wdata <= '0;

		perp_set = '{PERP_RESET, 16'd0, 16'd65535, 16'd6554, 16'($urandom), PERP_RESET};
		par_set = '{PARALLEL_RESET, 16'd65535, 16'd0, 16'd58982, 16'($urandom),
			PARALLEL_RESET};
		idle_set = '{26, 26, 69, 69, 0, 0};

		// directed rows, reset limits (cos bounds 0.02 / 0.98)
		add_row(vec(8192, 0, 0), vec(0, 0, 8192), vec(0, 8192, 0), vec(8192, 0, 0),
			KIND_HIRTH, 1);
		add_row(vec(8192, 0, 0), vec(0, 0, 8192), vec(8192, 0, 0), vec(0, 8192, 0),
			KIND_NONE, 1);
		add_row(vec(8192, 0, 0), vec(0, 0, 8192), vec(-8192, 0, 0), vec(0, 8192, 0),
			KIND_NONE, 1);
		add_row(vec(8192, 8192, 0), vec(0, 0, 8192), vec(8192, 0, 0), vec(0, 0, 8192),
			KIND_COPLANAR, 1);
		add_row(vec(8192, 0, 0), vec(0, 0, 8192), vec(8192, 8192, 0), vec(8192, 0, 0),
			KIND_GLISSILE, 1);
		add_row(vec(8192, 0, 0), vec(0, 8192, 8192), vec(8192, 8192, 0), vec(8192, 0, 8192),
			KIND_SESSILE, 1);
		// zero first Burgers vector skips both Burgers tests
		add_row(vec(0, 0, 0), vec(0, 0, 8192), vec(8192, 0, 0), vec(0, 8192, 0),
			KIND_GLISSILE, 1);
		// zero Burgers sum never glides
		add_row(vec(0, 0, 0), vec(0, 0, 8192), vec(0, 0, 0), vec(8192, 0, 0),
			KIND_SESSILE, 1);
		add_row(vec(-32768, -32768, -32768), vec(32767, 0, 0), vec(32767, 32767, 32767),
			vec(0, 32767, 0), KIND_NONE, 1);
		add_row(vec(-32768, -32768, -32768), vec(-32768, -32768, -32768),
			vec(-32768, -32768, -32768), vec(-32768, -32768, -32768), KIND_NONE, 1);
		add_row(vec(1, 0, 0), vec(0, 0, 1), vec(0, 1, 0), vec(1, 0, 0), KIND_HIRTH, 1);
		add_row(vec(32767, 32767, 32767), vec(32767, -32768, 0), vec(-32768, 32767, -32768),
			vec(0, 32767, -32768), KIND_NONE, 0);
		add_row(vec(8192, 0, 0), vec(0, 0, 0), vec(8192, 8192, 0), vec(0, 0, 0),
			KIND_NONE, 0);
		add_row(vec(8192, 0, 0), vec(8192, 8192, 8192), vec(0, 8192, 0), vec(0, 0, 8192),
			KIND_NONE, 0);
		// around the perpendicular and parallel bounds
		add_row(vec(8192, 0, 0), vec(0, 0, 8192), vec(163, 8192, 0), vec(8192, 0, 0),
			KIND_NONE, 0);
		add_row(vec(8192, 0, 0), vec(0, 0, 8192), vec(165, 8192, 0), vec(8192, 0, 0),
			KIND_NONE, 0);
		add_row(vec(8192, 0, 0), vec(0, 0, 8192), vec(8192, 1600, 0), vec(8192, 0, 0),
			KIND_NONE, 0);
		add_row(vec(8192, 0, 0), vec(0, 0, 8192), vec(8192, 1700, 0), vec(8192, 0, 0),
			KIND_NONE, 0);
		add_row(vec(8192, 0, 0), vec(0, 0, 8192), vec(4096, 8192, 0), vec(0, 1600, 8192),
			KIND_NONE, 0);
		add_row(vec(8192, 0, 0), vec(0, 0, 8192), vec(4096, 8192, 0), vec(0, 1700, 8192),
			KIND_NONE, 0);
		add_row(vec(-1, -1, -1), vec(1, -1, 0), vec(1, 1, -1), vec(-1, 0, 1), KIND_NONE, 0);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (stim_rows[k])
			send_pair(stim_rows[k].pair, 26, stim_rows[k].known, stim_rows[k].kind);
		drain_pipe();

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			if (ph != 0)
				program_limits(perp_set[ph], par_set[ph]);
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				// hold off mid-phase until the pipeline is empty
				if (ph == 3 && n == ITEMS_PER_PHASE / 2)
					drain_pipe();
				send_pair(random_pair(), idle_set[ph], 0, KIND_NONE);
			end
			drain_pipe();
		end

		repeat (PIPE_DRAIN) @(posedge clk);
		$display("ran %0d transactions over %0d limit settings incl. both extremes",
			sent_count, NUM_PHASES);
		$display("kinds seen: none %0d, hirth %0d, coplanar %0d, glissile %0d, sessile %0d",
			kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3], kind_seen[4]);
		if (mismatch_count == 0 && expected_kinds.size() == 0) begin
			$display("[slip_junction_classifier] OK");
		end else begin
			$display("[slip_junction_classifier] ERROR");
		end
		$finish;
	end

endmodule
